FILE: hw/rtl/lpm_pkg.sv
// Package: shared constants, types and a helper function for the route table.
package lpm_pkg;

   // Table geometry
   localparam int TableEntries = 32;
   localparam int PortCount    = 16;
   localparam int IdxW         = (TableEntries > 1) ? $clog2(TableEntries) : 1;

   // Field widths
   localparam int AddrW = 32;
   localparam int LenW  = 6;
   localparam int PortW = 4;
   localparam int TtlW  = 8;
   localparam int StatW = 3;

   localparam logic [LenW-1:0] MaxLen = LenW'(32);

   // Commands
   typedef enum logic {
      CMD_ADD    = 1'b0,
      CMD_LOOKUP = 1'b1
   } cmd_type;

   // Result status codes
   typedef enum logic [StatW-1:0] {
      ST_FORWARD  = 3'd0,
      ST_NO_ROUTE = 3'd1,
      ST_EXPIRED  = 3'd2,
      ST_STORED   = 3'd3,
      ST_FULL     = 3'd4
   } status_type;

   // Search key broadcast to every cell while an item is in flight
   typedef struct packed {
      cmd_type          cmd;
      logic [AddrW-1:0] addr;   // masked prefix for add, destination for lookup
      logic [LenW-1:0]  len;    // saturated prefix length for add
   } key_type;

   // Table write broadcast at the end of an add
   typedef struct packed {
      logic             en;
      logic [IdxW-1:0]  idx;
      logic [AddrW-1:0] prefix;
      logic [LenW-1:0]  len;
      logic             has_hop;
      logic [AddrW-1:0] hop;
      logic [PortW-1:0] port;
   } wr_type;

   // Running search state handed from cell to cell
   typedef struct packed {
      logic             active;
      logic             found;      // lookup: some entry matched
      logic [LenW-1:0]  best_len;
      logic [PortW-1:0] best_port;
      logic             best_has_hop;
      logic [AddrW-1:0] best_hop;
      logic             match_found; // add: same prefix and length exists
      logic [IdxW-1:0]  match_idx;
      logic             free_found;  // add: lowest free slot seen
      logic [IdxW-1:0]  free_idx;
   } token_type;

   // One result item
   typedef struct packed {
      status_type       status;
      logic [PortW-1:0] out_port;
      logic [AddrW-1:0] forward_addr;
      logic [TtlW-1:0]  new_hops_left;
   } result_type;

   // High-order mask of len bits; len is at most 32
   function automatic logic [AddrW-1:0] len_mask(input logic [LenW-1:0] len);
      logic [AddrW-1:0] m;
      if (len == '0) begin
         m = '0;
      end else if (len >= MaxLen) begin
         m = '1;
      end else begin
         m = {AddrW{1'b1}} << (MaxLen - len);
      end
      return m;
   endfunction

endpackage

FILE: hw/rtl/lpm_req_if.sv
// Interface: request channel carrying add and lookup items.
interface lpm_req_if;
   logic                          valid;
   logic                          ready;
   logic                          command;
   logic [lpm_pkg::AddrW-1:0]     route_addr;
   logic [lpm_pkg::LenW-1:0]      route_length;
   logic                          hop_given;
   logic [lpm_pkg::AddrW-1:0]     hop_addr;
   logic [lpm_pkg::PortW-1:0]     port_index;
   logic [lpm_pkg::AddrW-1:0]     dest_addr;
   logic [lpm_pkg::TtlW-1:0]      hops_left;

   modport source (
      output valid, command, route_addr, route_length, hop_given, hop_addr,
             port_index, dest_addr, hops_left,
      input  ready
   );
   modport sink (
      input  valid, command, route_addr, route_length, hop_given, hop_addr,
             port_index, dest_addr, hops_left,
      output ready
   );
endinterface

FILE: hw/rtl/lpm_rsp_if.sv
// Interface: response channel carrying one result item per request.
interface lpm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [lpm_pkg::StatW-1:0]     status;
   logic [lpm_pkg::PortW-1:0]     out_port;
   logic [lpm_pkg::AddrW-1:0]     forward_addr;
   logic [lpm_pkg::TtlW-1:0]      new_hops_left;

   modport source (
      output valid, status, out_port, forward_addr, new_hops_left,
      input  ready
   );
   modport sink (
      input  valid, status, out_port, forward_addr, new_hops_left,
      output ready
   );
endinterface

FILE: hw/rtl/longest_prefix_match_router_top.sv
// Top level: IPv4 longest-prefix-match route table built as a chain of entry cells.
//
// Each table entry lives in its own cell; an item's search token walks the chain one
// cell per cycle, and the item is resolved when its token leaves the chain. One item is
// in the chain at a time; the next is accepted once the previous leaves the chain and
// the spare result slot is empty, even while a result still waits on the response side
// (two-deep result buffer). An add writes the chosen slot by broadcast when its token
// leaves the chain: an existing entry with the same masked prefix and length first,
// else the lowest free slot; an add with an out-of-range port is refused as full. A
// lookup takes the longest matching prefix, lowest slot on ties.
module longest_prefix_match_router_top (
   input  logic        clock,
   input  logic        reset,
   lpm_req_if.sink     req_ch,
   lpm_rsp_if.source   rsp_ch
);

   // Item held for the whole search
   logic                        busy_ff,  busy_in;
   logic                        start_ff, start_in;
   lpm_pkg::key_type            key_ff,   key_in;
   logic                        has_hop_ff;
   logic [lpm_pkg::AddrW-1:0]   hop_ff;
   logic [lpm_pkg::PortW-1:0]   port_ff;
   logic                        port_ok_ff;
   logic [lpm_pkg::TtlW-1:0]    ttl_ff;

   // Output buffer: presented result and one spare
   logic                        rsp_valid_ff,  rsp_valid_in;
   lpm_pkg::result_type         rsp_data_ff,   rsp_data_in;
   logic                        hold_valid_ff, hold_valid_in;
   lpm_pkg::result_type         hold_data_ff,  hold_data_in;

   lpm_pkg::token_type          tok [lpm_pkg::TableEntries+1];
   lpm_pkg::token_type          tail;
   lpm_pkg::wr_type             wr;
   lpm_pkg::result_type         result;

   logic                        accept;
   logic [lpm_pkg::LenW-1:0]    sat_len;

   assign req_ch.ready = !busy_ff && !hold_valid_ff;
   assign accept       = req_ch.valid && req_ch.ready;
   assign tail         = tok[lpm_pkg::TableEntries];

   // Saturate the prefix length and build the search key
   always_comb begin
      sat_len = (req_ch.route_length > lpm_pkg::MaxLen) ? lpm_pkg::MaxLen
                                                        : req_ch.route_length;
      key_in  = key_ff;
      if (accept) begin
         key_in.cmd = lpm_pkg::cmd_type'(req_ch.command);
         key_in.len = sat_len;
         if (req_ch.command == lpm_pkg::CMD_LOOKUP) begin
            key_in.addr = req_ch.dest_addr;
         end else begin
            key_in.addr = req_ch.route_addr & lpm_pkg::len_mask(sat_len);
         end
      end
   end

   // Busy from acceptance until the token leaves the chain
   always_comb begin
      start_in = accept;
      busy_in  = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (tail.active) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         start_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         start_ff <= start_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      if (accept) begin
         has_hop_ff <= req_ch.hop_given;
         hop_ff     <= req_ch.hop_given ? req_ch.hop_addr : '0;
         port_ff    <= req_ch.port_index;
         port_ok_ff <= ({1'b0, req_ch.port_index} <
                        (lpm_pkg::PortW+1)'(lpm_pkg::PortCount));
         ttl_ff     <= req_ch.hops_left;
      end
   end

   // Fresh token into the head of the chain
   always_comb begin
      tok[0]        = '0;
      tok[0].active = start_ff;
   end

   // Chain of entry cells
   for (genvar i = 0; i < lpm_pkg::TableEntries; i++) begin : g_cell
      lpm_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (lpm_pkg::IdxW'(i)),
         .key        (key_ff),
         .wr         (wr),
         .token_in   (tok[i]),
         .token_out  (tok[i+1])
      );
   end

   // Resolve the item when its token leaves the chain
   always_comb begin
      wr         = '0;
      wr.prefix  = key_ff.addr;
      wr.len     = key_ff.len;
      wr.has_hop = has_hop_ff;
      wr.hop     = hop_ff;
      wr.port    = port_ff;
      result     = '0;
      if (key_ff.cmd == lpm_pkg::CMD_LOOKUP) begin
         if (!tail.found) begin
            result.status = lpm_pkg::ST_NO_ROUTE;
         end else if (ttl_ff <= lpm_pkg::TtlW'(1)) begin
            result.status = lpm_pkg::ST_EXPIRED;
         end else begin
            result.status        = lpm_pkg::ST_FORWARD;
            result.out_port      = tail.best_port;
            result.forward_addr  = tail.best_has_hop ? tail.best_hop : key_ff.addr;
            result.new_hops_left = ttl_ff - lpm_pkg::TtlW'(1);
         end
      end else begin
         if (!port_ok_ff) begin
            result.status = lpm_pkg::ST_FULL;
         end else if (tail.match_found) begin
            result.status = lpm_pkg::ST_STORED;
            wr.en         = tail.active;
            wr.idx        = tail.match_idx;
         end else if (tail.free_found) begin
            result.status = lpm_pkg::ST_STORED;
            wr.en         = tail.active;
            wr.idx        = tail.free_idx;
         end else begin
            result.status = lpm_pkg::ST_FULL;
         end
      end
   end

   // Output buffer management
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      hold_valid_in = hold_valid_ff;
      hold_data_in  = hold_data_ff;
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (hold_valid_ff && !rsp_valid_in) begin
         rsp_valid_in  = 1'b1;
         rsp_data_in   = hold_data_ff;
         hold_valid_in = 1'b0;
      end
      if (tail.active) begin
         if (!rsp_valid_in) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = result;
         end else begin
            hold_valid_in = 1'b1;
            hold_data_in  = result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      hold_data_ff <= hold_data_in;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.status        = rsp_data_ff.status;
   assign rsp_ch.out_port      = rsp_data_ff.out_port;
   assign rsp_ch.forward_addr  = rsp_data_ff.forward_addr;
   assign rsp_ch.new_hops_left = rsp_data_ff.new_hops_left;

endmodule

FILE: hw/rtl/lpm_cell.sv
// Module: one route table entry with its compare logic and a token stage.
module lpm_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [lpm_pkg::IdxW-1:0]    cell_index,
   input  lpm_pkg::key_type            key,
   input  lpm_pkg::wr_type             wr,
   input  lpm_pkg::token_type          token_in,
   output lpm_pkg::token_type          token_out
);

   logic                        valid_ff;
   logic [lpm_pkg::AddrW-1:0]   prefix_ff;
   logic [lpm_pkg::LenW-1:0]    len_ff;
   logic                        has_hop_ff;
   logic [lpm_pkg::AddrW-1:0]   hop_ff;
   logic [lpm_pkg::PortW-1:0]   port_ff;
   lpm_pkg::token_type          token_ff;
   lpm_pkg::token_type          token_next_in;

   logic wr_here;
   logic lookup_hit;
   logic exact_hit;

   assign wr_here = wr.en && (wr.idx == cell_index);

   // Entry storage; only the valid bit is reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (wr_here) begin
         valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_here) begin
         prefix_ff  <= wr.prefix;
         len_ff     <= wr.len;
         has_hop_ff <= wr.has_hop;
         hop_ff     <= wr.hop;
         port_ff    <= wr.port;
      end
   end

   // Compares against the broadcast key
   assign lookup_hit = valid_ff &&
                       ((key.addr & lpm_pkg::len_mask(len_ff)) == prefix_ff);
   assign exact_hit  = valid_ff && (len_ff == key.len) && (prefix_ff == key.addr);

   // Update the running search state
   always_comb begin
      token_next_in = token_in;
      if (token_in.active) begin
         if (key.cmd == lpm_pkg::CMD_LOOKUP) begin
            if (lookup_hit && (!token_in.found || (len_ff > token_in.best_len))) begin
               token_next_in.found        = 1'b1;
               token_next_in.best_len     = len_ff;
               token_next_in.best_port    = port_ff;
               token_next_in.best_has_hop = has_hop_ff;
               token_next_in.best_hop     = hop_ff;
            end
         end else begin
            if (exact_hit && !token_in.match_found) begin
               token_next_in.match_found = 1'b1;
               token_next_in.match_idx   = cell_index;
            end
            if (!valid_ff && !token_in.free_found) begin
               token_next_in.free_found = 1'b1;
               token_next_in.free_idx   = cell_index;
            end
         end
      end
   end

   // Token stage toward the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         token_ff.active <= 1'b0;
      end else begin
         token_ff <= token_next_in;
      end
   end

   assign token_out = token_ff;

endmodule

FILE: tb/sv/longest_prefix_match_router_top_test.sv
// Self-checking testbench for the route table: directed rows, then random adds and lookups.
module longest_prefix_match_router_top_test;
   import lpm_pkg::*;

   localparam int RandomItems = 1450;
   localparam int EarlyItems  = 900;   // no default route and no fresh keys before this
   localparam int QuietItems  = 150;   // tail of the run with both sides streaming
   localparam int PoolKeys    = 20;
   localparam int DrainCycles = 2 * (TableEntries + 2);
   localparam int CycleLimit  = 500000;
   localparam int DirRows     = 22;

   // One request item as the testbench sees it
   typedef struct {
      cmd_type          cmd;
      logic [AddrW-1:0] route_addr;
      logic [LenW-1:0]  route_len;
      logic             hop_given;
      logic [AddrW-1:0] hop_addr;
      logic [PortW-1:0] port;
      logic [AddrW-1:0] dest;
      logic [TtlW-1:0]  ttl;
   } route_req_type;

   // Directed row: status typed in only where it is obvious
   typedef struct {
      route_req_type req;
      bit            typed;
      status_type    status;
   } route_row_type;

   // Shadow route entry
   typedef struct {
      logic             valid;
      logic [AddrW-1:0] prefix;
      logic [LenW-1:0]  len;
      logic             has_hop;
      logic [AddrW-1:0] hop;
      logic [PortW-1:0] port;
   } route_entry_type;

   logic clock;
   logic reset;

   lpm_req_if req_bus ();
   lpm_rsp_if rsp_bus ();

   longest_prefix_match_router_top u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   route_entry_type  route_tab [TableEntries];
   result_type       route_results_due [$];
   logic [AddrW-1:0] pool_addr [PoolKeys];
   logic [LenW-1:0]  pool_len  [PoolKeys];
   int               mismatches = 0;
   int               results_seen = 0;
   int               cycles = 0;
   bit               req_idle_on = 1'b1;
   bit               rsp_idle_on = 1'b1;

   route_row_type directed_rows [DirRows] = '{
      // empty table: every lookup misses
      '{'{CMD_LOOKUP, 32'h0000_0000, 6'd0,  1'b0, 32'h0000_0000, 4'd0,
          32'h0000_0000, 8'd64},  1'b1, ST_NO_ROUTE},
      '{'{CMD_LOOKUP, 32'hffff_ffff, 6'd63, 1'b1, 32'hffff_ffff, 4'd15,
          32'hffff_ffff, 8'd255}, 1'b1, ST_NO_ROUTE},
      // routes of several lengths, host route and saturated length
      '{'{CMD_ADD,    32'hffff_ffff, 6'd32, 1'b1, 32'h0a00_0001, 4'd15,
          32'hffff_ffff, 8'd255}, 1'b1, ST_STORED},
      '{'{CMD_ADD,    32'hc0a8_0123, 6'd24, 1'b0, 32'hdead_beef, 4'd0,
          32'h0000_0000, 8'd0},   1'b1, ST_STORED},
      '{'{CMD_ADD,    32'hc0a8_ffff, 6'd16, 1'b1, 32'hc0a8_0001, 4'd3,
          32'h1234_5678, 8'd17},  1'b1, ST_STORED},
      '{'{CMD_ADD,    32'h0a0b_0c0d, 6'd63, 1'b0, 32'h1234_5678, 4'd7,
          32'h0000_0000, 8'd1},   1'b1, ST_STORED},
      '{'{CMD_ADD,    32'h8000_0000, 6'd1,  1'b1, 32'hffff_ffff, 4'd9,
          32'hffff_ffff, 8'd0},   1'b1, ST_STORED},
      // forwarding, expiry and misses
      '{'{CMD_LOOKUP, 32'h0000_0000, 6'd0,  1'b0, 32'h0000_0000, 4'd0,
          32'hffff_ffff, 8'd255}, 1'b0, ST_FORWARD},
      '{'{CMD_LOOKUP, 32'h5555_5555, 6'd21, 1'b1, 32'haaaa_aaaa, 4'd10,
          32'hc0a8_0177, 8'd2},   1'b0, ST_FORWARD},
      '{'{CMD_LOOKUP, 32'h0000_0000, 6'd0,  1'b0, 32'h0000_0000, 4'd0,
          32'hc0a8_0277, 8'd1},   1'b0, ST_FORWARD},
      '{'{CMD_LOOKUP, 32'hffff_ffff, 6'd63, 1'b1, 32'hffff_ffff, 4'd15,
          32'hc0a8_0177, 8'd0},   1'b0, ST_FORWARD},
      '{'{CMD_LOOKUP, 32'h0000_0000, 6'd0,  1'b0, 32'h0000_0000, 4'd0,
          32'h0a0b_0c0d, 8'd10},  1'b0, ST_FORWARD},
      '{'{CMD_LOOKUP, 32'h0000_0000, 6'd0,  1'b0, 32'h0000_0000, 4'd0,
          32'h0a0b_0c0c, 8'd10},  1'b0, ST_FORWARD},
      '{'{CMD_LOOKUP, 32'h0000_0000, 6'd0,  1'b0, 32'h0000_0000, 4'd0,
          32'h0000_0001, 8'd0},   1'b0, ST_FORWARD},
      // overwrite of an existing prefix and length
      '{'{CMD_ADD,    32'hc0a8_0000, 6'd16, 1'b0, 32'h7777_7777, 4'd5,
          32'h0000_0000, 8'd0},   1'b1, ST_STORED},
      '{'{CMD_LOOKUP, 32'h0000_0000, 6'd0,  1'b0, 32'h0000_0000, 4'd0,
          32'hc0a8_5555, 8'd128}, 1'b0, ST_FORWARD},
      '{'{CMD_ADD,    32'h0a0b_0c0d, 6'd32, 1'b1, 32'h0102_0304, 4'd12,
          32'h0000_0000, 8'd0},   1'b1, ST_STORED},
      '{'{CMD_LOOKUP, 32'h0000_0000, 6'd0,  1'b0, 32'h0000_0000, 4'd0,
          32'h0a0b_0c0d, 8'd255}, 1'b0, ST_FORWARD},
      '{'{CMD_LOOKUP, 32'h0000_0000, 6'd0,  1'b0, 32'h0000_0000, 4'd0,
          32'h9abc_def0, 8'd255}, 1'b0, ST_FORWARD},
      '{'{CMD_ADD,    32'h00ab_cdef, 6'd8,  1'b1, 32'h0000_0000, 4'd15,
          32'h0000_0000, 8'd0},   1'b1, ST_STORED},
      '{'{CMD_LOOKUP, 32'h0000_0000, 6'd0,  1'b0, 32'h0000_0000, 4'd0,
          32'h00ff_ffff, 8'd3},   1'b0, ST_FORWARD},
      '{'{CMD_LOOKUP, 32'h0000_0000, 6'd0,  1'b0, 32'h0000_0000, 4'd0,
          32'hc0a8_0123, 8'd255}, 1'b0, ST_FORWARD}
   };

   // Clamp prefix length to the address width
   function automatic logic [LenW-1:0] sat_len(input logic [LenW-1:0] n);
      return (n > LenW'(AddrW)) ? LenW'(AddrW) : n;
   endfunction

   // High-order mask for a clamped length; a shift by the full width gives zero
   function automatic logic [AddrW-1:0] prefix_mask(input logic [LenW-1:0] n);
      logic [AddrW-1:0] ones;
      ones = '1;
      return ones << (AddrW - int'(n));
   endfunction

   // Apply one item to the shadow table and work out its result
   function automatic result_type route_decision(input route_req_type r);
      result_type       res;
      logic [LenW-1:0]  len;
      logic [AddrW-1:0] prefix;
      int               slot;
      int               best;
      res.status        = ST_FORWARD;
      res.out_port      = '0;
      res.forward_addr  = '0;
      res.new_hops_left = '0;
      slot = -1;
      best = -1;
      if (r.cmd == CMD_ADD) begin
         len    = sat_len(r.route_len);
         prefix = r.route_addr & prefix_mask(len);
         if (int'(r.port) >= PortCount) begin
            res.status = ST_FULL;
            return res;
         end
         // same prefix and length first, else lowest free slot
         for (int i = 0; i < TableEntries; i++) begin
            if (slot < 0 && route_tab[i].valid && route_tab[i].len == len &&
                route_tab[i].prefix == prefix) begin
               slot = i;
            end
         end
         for (int i = 0; i < TableEntries; i++) begin
            if (slot < 0 && !route_tab[i].valid) begin
               slot = i;
            end
         end
         if (slot < 0) begin
            res.status = ST_FULL;
         end else begin
            route_tab[slot].valid   = 1'b1;
            route_tab[slot].prefix  = prefix;
            route_tab[slot].len     = len;
            route_tab[slot].has_hop = r.hop_given;
            route_tab[slot].hop     = r.hop_given ? r.hop_addr : '0;
            route_tab[slot].port    = r.port;
            res.status = ST_STORED;
         end
         return res;
      end
      // longest match wins, lowest slot on equal length
      for (int i = 0; i < TableEntries; i++) begin
         if (route_tab[i].valid &&
             (r.dest & prefix_mask(route_tab[i].len)) == route_tab[i].prefix &&
             (best < 0 || route_tab[i].len > route_tab[best].len)) begin
            best = i;
         end
      end
      if (best < 0) begin
         res.status = ST_NO_ROUTE;
      end else if (r.ttl <= 8'd1) begin
         res.status = ST_EXPIRED;
      end else begin
         res.out_port      = route_tab[best].port;
         res.forward_addr  = route_tab[best].has_hop ? route_tab[best].hop : r.dest;
         res.new_hops_left = r.ttl - 8'd1;
      end
      return res;
   endfunction

   // Random item: mostly drawn from the nested key pool, some pure noise
   function automatic route_req_type random_route_req(input bit late);
      route_req_type    r;
      int               k;
      int               pick;
      int               b;
      logic [LenW-1:0]  len;
      logic [AddrW-1:0] m;
      r.cmd        = ($urandom_range(0, 9) < 4) ? CMD_ADD : CMD_LOOKUP;
      r.route_addr = $urandom;
      r.route_len  = LenW'($urandom_range(0, 63));
      r.hop_given  = 1'($urandom_range(0, 1));
      r.hop_addr   = $urandom;
      r.port       = PortW'($urandom_range(0, 15));
      r.dest       = $urandom;
      r.ttl        = TtlW'($urandom_range(0, 255));
      k    = $urandom_range(0, PoolKeys - 1);
      len  = sat_len(pool_len[k]);
      m    = prefix_mask(len);
      pick = $urandom_range(0, 9);
      if (r.cmd == CMD_ADD) begin
         // fresh keys only late, so the table fills up there
         if (!(late && pick < 3)) begin
            r.route_addr = (pool_addr[k] & m) | (r.route_addr & ~m);
            r.route_len  = pool_len[k];
         end
      end else begin
         if (pick < 8) begin
            r.dest = (pool_addr[k] & m) | (r.dest & ~m);
         end
         // near miss: one bit inside the prefix flipped
         if (pick == 7 && len != '0) begin
            b = $urandom_range(AddrW - int'(len), AddrW - 1);
            r.dest[b] = ~r.dest[b];
         end
         case ($urandom_range(0, 9))
            0: r.ttl = 8'd0;
            1: r.ttl = 8'd1;
            2: r.ttl = 8'd2;
            3: r.ttl = 8'd255;
            default: ;
         endcase
      end
      return r;
   endfunction

   function automatic void log_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%s", msg);
      end
   endfunction

   // Present one item, wait for its acceptance, record the expected result
   task automatic drive_route_req(input route_req_type r, input bit typed,
                                  input status_type typed_status);
      result_type exp;
      if (req_idle_on && $urandom_range(0, 5) == 0) begin
         req_bus.valid = 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_bus.valid        = 1'b1;
      req_bus.command      = r.cmd;
      req_bus.route_addr   = r.route_addr;
      req_bus.route_length = r.route_len;
      req_bus.hop_given    = r.hop_given;
      req_bus.hop_addr     = r.hop_addr;
      req_bus.port_index   = r.port;
      req_bus.dest_addr    = r.dest;
      req_bus.hops_left    = r.ttl;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      exp = route_decision(r);
      if (typed) begin
         exp.status        = typed_status;
         exp.out_port      = '0;
         exp.forward_addr  = '0;
         exp.new_hops_left = '0;
      end
      route_results_due.push_back(exp);
      @(negedge clock);
   endtask

   // Clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Result side ready, stalled in random bursts
   initial begin
      int stall_left;
      stall_left    = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready = 1'b0;
         end else if (rsp_idle_on && $urandom_range(0, 7) == 0) begin
            stall_left    = $urandom_range(1, 15) - 1;
            rsp_bus.ready = 1'b0;
         end else begin
            rsp_bus.ready = 1'b1;
         end
      end
   end

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      result_type exp;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (route_results_due.size() == 0) begin
            log_mismatch($sformatf("unexpected result: status %0d port %0d fwd %h ttl %0d",
                                   rsp_bus.status, rsp_bus.out_port,
                                   rsp_bus.forward_addr, rsp_bus.new_hops_left));
         end else begin
            exp = route_results_due.pop_front();
            if (rsp_bus.status !== exp.status || rsp_bus.out_port !== exp.out_port ||
                rsp_bus.forward_addr !== exp.forward_addr ||
                rsp_bus.new_hops_left !== exp.new_hops_left) begin
               log_mismatch($sformatf({"result %0d: expected status %0d port %0d fwd %h ",
                                       "ttl %0d, got status %0d port %0d fwd %h ttl %0d"},
                                      results_seen, exp.status, exp.out_port,
                                      exp.forward_addr, exp.new_hops_left, rsp_bus.status,
                                      rsp_bus.out_port, rsp_bus.forward_addr,
                                      rsp_bus.new_hops_left));
            end
            results_seen++;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles == CycleLimit) begin
         $display("** longest_prefix_match_router_top: FAILED **");
         $finish;
      end
   end

   // Main sequence
   initial begin
      route_req_type r;
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.command      = CMD_ADD;
      req_bus.route_addr   = '0;
      req_bus.route_length = '0;
      req_bus.hop_given    = 1'b0;
      req_bus.hop_addr     = '0;
      req_bus.port_index   = '0;
      req_bus.dest_addr    = '0;
      req_bus.hops_left    = '0;
      foreach (route_tab[i]) route_tab[i].valid = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed rows
      foreach (directed_rows[i]) begin
         drive_route_req(directed_rows[i].req, directed_rows[i].typed,
                         directed_rows[i].status);
      end

      // nested keys: four base addresses, several lengths each
      for (int i = 0; i < PoolKeys; i++) begin
         pool_addr[i] = (i < 4) ? AddrW'($urandom) : pool_addr[i % 4];
         pool_len[i]  = LenW'($urandom_range(1, 63));
      end

      // random part; the default route goes in at the start of the late phase
      for (int n = 0; n < RandomItems; n++) begin
         if (n % 50 == 0) begin
            req_idle_on = (n < RandomItems - QuietItems) && $urandom_range(0, 2) != 0;
            rsp_idle_on = (n < RandomItems - QuietItems) && $urandom_range(0, 2) != 0;
         end
         r = random_route_req(n >= EarlyItems);
         if (n == EarlyItems) begin
            r.cmd       = CMD_ADD;
            r.route_len = '0;
         end
         drive_route_req(r, 1'b0, ST_FORWARD);
      end
      req_bus.valid = 1'b0;

      // drain
      while (route_results_due.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (mismatches == 0) begin
         $display("** longest_prefix_match_router_top: PASSED **");
      end else begin
         $display("** longest_prefix_match_router_top: FAILED **");
      end
      $finish;
   end

endmodule
